@@ rtl/core/sha256_pkg.sv @@
// sha256_pkg: shared types, constants and functions of the sha-256 hasher
// no dependencies

package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } ctrl_state_t;

    // word source for the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    typedef struct packed {
        logic       load_word;    // write a word into the buffer
        word_src_t  src;
        logic       add_bits;     // add input bit count to length
        logic       start_block;  // load working vars from chain
        logic       do_round;
        logic       fold;         // chain += working vars
        logic       shift_out;    // rotate chain for digest output
        logic       reinit;       // reset chain, length, position
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;   // position wrapped to zero on last write
        logic [3:0] position;
        logic       round_last;
    } dp_stat_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/core/sha256_if.sv @@
// sha256_msg_if / sha256_dig_if: valid-ready channels of the hasher
// depends on nothing

interface sha256_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic        final_word;
    logic [2:0]  valid_bytes;
    modport source (output valid, message_word, final_word, valid_bytes, input ready);
    modport sink (input valid, message_word, final_word, valid_bytes, output ready);
endinterface

interface sha256_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink (input valid, digest_word, digest_last, output ready);
endinterface

@@ rtl/core/sha256_datapath.sv @@
// sha256_datapath: block buffer, message schedule, round unit, chain and length
// depends on sha256_pkg

module sha256_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::dp_cmd_t   cmd,
    input  logic [31:0]           in_word,
    input  logic [3:0]            in_bits_bytes,
    output sha256_pkg::dp_stat_t  stat,
    output logic [31:0]           chain0
);

    logic [31:0] block_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [5:0]  rnd_reg;
    logic [5:0]  rnd_next;
    logic [31:0] wr_word;
    logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
    logic        full_reg;
    logic        full_next;

    always_comb
    begin
        case (cmd.src)
            sha256_pkg::SRC_INPUT:  wr_word = in_word;
            sha256_pkg::SRC_ZERO:   wr_word = '0;
            sha256_pkg::SRC_LEN_HI: wr_word = len_reg[63:32];
            sha256_pkg::SRC_LEN_LO: wr_word = len_reg[31:0];
            default:                wr_word = '0;
        endcase
    end

    // schedule: 16-word window shifts left each round
    assign s0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
              ^ (w_reg[1] >> 3);
    assign s1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];

    assign big1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
                ^ sha256_pkg::rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + sha256_pkg::K_TAB[rnd_reg] + w_reg[0];
    assign big0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
                ^ sha256_pkg::rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_comb
    begin
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        full_next = 1'b0;
        if (cmd.load_word)
        begin
            pos_next = pos_reg + 4'd1;
            full_next = (pos_reg == 4'd15);
        end
        if (cmd.add_bits)
            len_next = len_reg + {57'd0, in_bits_bytes, 3'd0};
        if (cmd.start_block)
        begin
            w_next = block_reg;
            v_next = h_reg;
            rnd_next = '0;
        end
        if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.fold)
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        if (cmd.shift_out)
        begin
            for (int i = 0; i < 7; i++)
                h_next[i] = h_reg[i + 1];
            h_next[7] = h_reg[0];
        end
        if (cmd.reinit)
        begin
            h_next = sha256_pkg::H_INIT;
            pos_next = '0;
            len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha256_pkg::H_INIT;
            pos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            h_reg <= h_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
        if (cmd.load_word)
            block_reg[pos_reg] <= wr_word;
    end

    assign stat.block_full = full_reg;
    assign stat.position = pos_reg;
    assign stat.round_last = (rnd_reg == 6'(sha256_pkg::ROUNDS - 1));
    assign chain0 = h_reg[0];

endmodule

@@ rtl/core/sha256_ctrl.sv @@
// sha256_ctrl: sequencer for word intake, rounds, padding and digest output
// depends on sha256_pkg, sha256_if

module sha256_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    sha256_msg_if.sink            msg,
    input  logic                  dig_ready,
    output logic                  dig_valid,
    output logic                  dig_last,
    input  sha256_pkg::dp_stat_t  stat,
    output sha256_pkg::dp_cmd_t   cmd,
    output logic [31:0]           in_word,
    output logic [3:0]            in_bits_bytes
);

    sha256_pkg::ctrl_state_t state_reg, state_next;
    // padding phase: 0 marker word pending, 1 zero fill, 2 len hi, 3 len lo
    logic [1:0] pad_reg, pad_next;
    logic       fin_reg, fin_next;   // a final word is being closed out
    logic [2:0] cnt_reg, cnt_next;
    logic       chk_reg, chk_next;   // check block_full after a write
    logic [2:0] nb;
    logic [31:0] keep, marker;

    assign nb = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;

    always_comb
    begin
        case (nb)
            3'd0:    keep = 32'h00000000;
            3'd1:    keep = 32'hff000000;
            3'd2:    keep = 32'hffff0000;
            3'd3:    keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        case (nb)
            3'd0:    marker = 32'h80000000;
            3'd1:    marker = 32'h00800000;
            3'd2:    marker = 32'h00008000;
            default: marker = 32'h00000080;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pad_next = pad_reg;
        fin_next = fin_reg;
        cnt_next = cnt_reg;
        chk_next = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (chk_reg && stat.block_full)
                    state_next = sha256_pkg::ST_ROUND;
                else if (fin_reg)
                    state_next = sha256_pkg::ST_PAD;
                else if (msg.valid)
                begin
                    chk_next = 1'b1;
                    if (msg.final_word)
                    begin
                        fin_next = 1'b1;
                        // a padded final word landing in slot 13 leaves room for the length
                        pad_next = (nb == 3'd4) ? 2'd0 :
                                   ((stat.position == 4'd13) ? 2'd2 : 2'd1);
                    end
                end
            end
            sha256_pkg::ST_ROUND:
                if (stat.round_last)
                    state_next = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD:
            begin
                if (!fin_reg)
                    state_next = sha256_pkg::ST_IDLE;
                else if (pad_reg == 2'd3)
                begin
                    state_next = sha256_pkg::ST_EMIT;
                    cnt_next = '0;
                end
                else
                    state_next = sha256_pkg::ST_PAD;
            end
            sha256_pkg::ST_PAD:
            begin
                if (chk_reg && stat.block_full)
                    state_next = sha256_pkg::ST_ROUND;
                else
                begin
                    chk_next = 1'b1;
                    case (pad_reg)
                        2'd0: pad_next = (stat.position == 4'd13) ? 2'd2 : 2'd1;
                        2'd1: if (stat.position == 4'd13) pad_next = 2'd2;
                        2'd2: pad_next = 2'd3;
                        default: pad_next = 2'd3;
                    endcase
                end
            end
            sha256_pkg::ST_EMIT:
                if (dig_ready)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                        fin_next = 1'b0;
                    end
                end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.src = sha256_pkg::SRC_INPUT;
        msg.ready = 1'b0;
        dig_valid = 1'b0;
        dig_last = 1'b0;
        in_word = msg.message_word;
        in_bits_bytes = 4'd4;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (chk_reg && stat.block_full)
                    cmd.start_block = 1'b1;
                else if (!fin_reg)
                begin
                    msg.ready = 1'b1;
                    if (msg.valid)
                    begin
                        cmd.load_word = 1'b1;
                        cmd.add_bits = 1'b1;
                        if (msg.final_word)
                        begin
                            in_bits_bytes = {1'b0, nb};
                            if (nb != 3'd4)
                                in_word = (msg.message_word & keep) | marker;
                        end
                    end
                end
            end
            sha256_pkg::ST_ROUND:
                cmd.do_round = 1'b1;
            sha256_pkg::ST_FOLD:
                cmd.fold = 1'b1;
            sha256_pkg::ST_PAD:
            begin
                if (chk_reg && stat.block_full)
                    cmd.start_block = 1'b1;
                else
                begin
                    cmd.load_word = 1'b1;
                    case (pad_reg)
                        2'd0:
                        begin
                            cmd.src = sha256_pkg::SRC_INPUT;
                            in_word = 32'h80000000;
                        end
                        2'd1:    cmd.src = sha256_pkg::SRC_ZERO;
                        2'd2:    cmd.src = sha256_pkg::SRC_LEN_HI;
                        default: cmd.src = sha256_pkg::SRC_LEN_LO;
                    endcase
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                dig_valid = 1'b1;
                dig_last = (cnt_reg == 3'd7);
                if (dig_ready)
                begin
                    cmd.shift_out = 1'b1;
                    cmd.reinit = (cnt_reg == 3'd7);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            pad_reg <= '0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
            chk_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg <= pad_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
            chk_reg <= chk_next;
        end
    end

endmodule

@@ rtl/core/sha256_message_hasher_unit.sv @@
// sha256_message_hasher_unit: top level of the sha-256 message hasher
// depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_datapath
//
// msg channel: one 32-bit big-endian message word per item; final_word marks
// the last item and valid_bytes (0..4, above 4 taken as 4) counts its valid
// upper bytes. dig channel: eight digest items, h0 first, digest_last on the
// eighth. after the digest the hash state returns to the initial values.
// a word that does not fill a block is taken without holding off the next word. the
// sixteenth word of a block starts the compression: one round per cycle on a
// single round unit, in the steps load, 64 rounds and fold. the final word adds
// padding writes and one or two block compressions before the first digest
// item appears. input is held off while a block compresses, during padding and
// while the digest is shown. a stalled receiver holds the current digest item;
// nothing is lost. reset is asynchronous, active low, and clears the chain to
// the initial hash values, the length and the word position.

module sha256_message_hasher_unit (
    input  logic          clk,
    input  logic          rst_n,
    sha256_msg_if.sink    msg,
    sha256_dig_if.source  dig
);

    sha256_pkg::dp_cmd_t  cmd;
    sha256_pkg::dp_stat_t stat;
    logic [31:0]          in_word;
    logic [3:0]           in_bits_bytes;

    sha256_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg           (msg),
        .dig_ready     (dig.ready),
        .dig_valid     (dig.valid),
        .dig_last      (dig.digest_last),
        .stat          (stat),
        .cmd           (cmd),
        .in_word       (in_word),
        .in_bits_bytes (in_bits_bytes)
    );

    sha256_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_word       (in_word),
        .in_bits_bytes (in_bits_bytes),
        .stat          (stat),
        .chain0        (dig.digest_word)
    );

endmodule
